// File: hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, pipeline stage map and word types shared by the triangle unit
// normal block and its checker.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int unsigned COORD_BITS       = 32;
  localparam int unsigned NORMAL_FRAC_BITS = 14;
  localparam int unsigned OUT_BITS         = NORMAL_FRAC_BITS + 2;

  localparam int unsigned EDGE_BITS  = COORD_BITS + 1;
  localparam int unsigned PROD_BITS  = 2 * EDGE_BITS;
  localparam int unsigned CROSS_BITS = PROD_BITS + 1;
  localparam int unsigned MAG_BITS   = 2 * COORD_BITS + 1;
  localparam int unsigned LO_BITS    = (MAG_BITS + 1) / 2;
  localparam int unsigned HI_BITS    = MAG_BITS - LO_BITS;
  localparam int unsigned LL_BITS    = 2 * LO_BITS;
  localparam int unsigned LH_BITS    = LO_BITS + HI_BITS;
  localparam int unsigned HH_BITS    = 2 * HI_BITS;
  localparam int unsigned SQ_BITS    = 2 * MAG_BITS;
  localparam int unsigned SUM_BITS   = SQ_BITS + 2;
  localparam int unsigned REM_BITS   = SUM_BITS + 1;
  localparam int unsigned QUO_BITS   = 2 * NORMAL_FRAC_BITS + 3;
  localparam int unsigned ROOT_BITS  = NORMAL_FRAC_BITS + 2;
  localparam int unsigned SR_BITS    = 2 * ROOT_BITS + 1;

  localparam int unsigned ST_EDGE    = 0;
  localparam int unsigned ST_PROD    = 1;
  localparam int unsigned ST_CROSS   = 2;
  localparam int unsigned ST_PART    = 3;
  localparam int unsigned ST_SQ      = 4;
  localparam int unsigned ST_SUM     = 5;
  localparam int unsigned ST_DIV     = 6;
  localparam int unsigned ST_ROOT    = ST_DIV + QUO_BITS;
  localparam int unsigned ST_OUT     = ST_ROOT + ROOT_BITS;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  localparam logic signed [OUT_BITS-1:0] NORMAL_ONE =
    OUT_BITS'(1) << NORMAL_FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] normal_x;
    logic signed [OUT_BITS-1:0] normal_y;
    logic signed [OUT_BITS-1:0] normal_z;
    logic                       degenerate;
  } out_t;

endpackage

// File: hdl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Fully pipelined unit face normal of a triangle, Q16.16 in, Q1.14 out.
// ----------------------------------------------------------------------------
// The block takes one triangle word per cycle when nothing stalls and passes
// it through these stages in order: six stages form the edges, the cross
// product, its squared components and their sum, 31 stages do one quotient
// bit each of the squared component over the squared length, 16 stages do one
// bit each of the square root, and one stage rounds and registers the result.
// Each stage moves on as soon as the stage after it frees up, so a stall on
// the output first closes the gaps between words, and the input stalls only
// once all 54 stages hold words; from then on in_stall_o follows out_stall_i
// in the same cycle.
module triangle_unit_normal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tun_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tun_pkg::out_t out_data_o
);

  localparam int unsigned NS = tun_pkg::NUM_STAGES;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] mv;

  assign mv[NS-1] = !vld_q[NS-1] || !out_stall_i;

  for (genvar k = 0; k < NS - 1; k++) begin : g_move
    assign mv[k] = !vld_q[k] || mv[k+1];
  end

  for (genvar k = 0; k < NS; k++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (mv[k]) begin
        if (k == 0) begin
          vld_q[k] <= in_valid_i;
        end else begin
          vld_q[k] <= vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall_o = !mv[0];

  // Edges.
  logic signed [tun_pkg::COORD_BITS-1:0] cor_a [3];
  logic signed [tun_pkg::COORD_BITS-1:0] cor_b [3];
  logic signed [tun_pkg::COORD_BITS-1:0] cor_c [3];
  logic signed [tun_pkg::EDGE_BITS-1:0]  edge_u_q [3];
  logic signed [tun_pkg::EDGE_BITS-1:0]  edge_v_q [3];

  assign cor_a[0] = in_data_i.a_x;
  assign cor_a[1] = in_data_i.a_y;
  assign cor_a[2] = in_data_i.a_z;
  assign cor_b[0] = in_data_i.b_x;
  assign cor_b[1] = in_data_i.b_y;
  assign cor_b[2] = in_data_i.b_z;
  assign cor_c[0] = in_data_i.c_x;
  assign cor_c[1] = in_data_i.c_y;
  assign cor_c[2] = in_data_i.c_z;

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_EDGE]) begin
      for (int i = 0; i < 3; i++) begin
        edge_u_q[i] <= tun_pkg::EDGE_BITS'(cor_b[i]) - tun_pkg::EDGE_BITS'(cor_a[i]);
        edge_v_q[i] <= tun_pkg::EDGE_BITS'(cor_c[i]) - tun_pkg::EDGE_BITS'(cor_a[i]);
      end
    end
  end

  // Cross product terms.
  logic signed [tun_pkg::PROD_BITS-1:0] prod_q [6];

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_PROD]) begin
      prod_q[0] <= tun_pkg::PROD_BITS'(edge_u_q[1]) * tun_pkg::PROD_BITS'(edge_v_q[2]);
      prod_q[1] <= tun_pkg::PROD_BITS'(edge_u_q[2]) * tun_pkg::PROD_BITS'(edge_v_q[1]);
      prod_q[2] <= tun_pkg::PROD_BITS'(edge_u_q[2]) * tun_pkg::PROD_BITS'(edge_v_q[0]);
      prod_q[3] <= tun_pkg::PROD_BITS'(edge_u_q[0]) * tun_pkg::PROD_BITS'(edge_v_q[2]);
      prod_q[4] <= tun_pkg::PROD_BITS'(edge_u_q[0]) * tun_pkg::PROD_BITS'(edge_v_q[1]);
      prod_q[5] <= tun_pkg::PROD_BITS'(edge_u_q[1]) * tun_pkg::PROD_BITS'(edge_v_q[0]);
    end
  end

  // Cross product as sign and magnitude.
  logic signed [tun_pkg::CROSS_BITS-1:0] cross_c [3];
  logic        [tun_pkg::CROSS_BITS-1:0] cross_abs [3];
  logic        [tun_pkg::MAG_BITS-1:0]   mag_q [3];
  logic        [2:0]                     neg_q [NS-2:tun_pkg::ST_CROSS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_c[i]   = tun_pkg::CROSS_BITS'(prod_q[2*i]) -
                     tun_pkg::CROSS_BITS'(prod_q[2*i+1]);
      cross_abs[i] = cross_c[i][tun_pkg::CROSS_BITS-1] ? -cross_c[i] : cross_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_CROSS]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]                    <= cross_abs[i][tun_pkg::MAG_BITS-1:0];
        neg_q[tun_pkg::ST_CROSS][i] <= cross_c[i][tun_pkg::CROSS_BITS-1];
      end
    end
  end

  for (genvar k = tun_pkg::ST_CROSS + 1; k < NS - 1; k++) begin : g_neg
    always_ff @(posedge clk_i) begin
      if (mv[k]) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Squares of the components, split into partial products.
  logic [tun_pkg::LL_BITS-1:0] part_ll_q [3];
  logic [tun_pkg::LH_BITS-1:0] part_lh_q [3];
  logic [tun_pkg::HH_BITS-1:0] part_hh_q [3];
  logic [tun_pkg::SQ_BITS-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_PART]) begin
      for (int i = 0; i < 3; i++) begin
        part_ll_q[i] <= tun_pkg::LL_BITS'(mag_q[i][tun_pkg::LO_BITS-1:0]) *
                        tun_pkg::LL_BITS'(mag_q[i][tun_pkg::LO_BITS-1:0]);
        part_lh_q[i] <= tun_pkg::LH_BITS'(mag_q[i][tun_pkg::LO_BITS-1:0]) *
                        tun_pkg::LH_BITS'(mag_q[i][tun_pkg::MAG_BITS-1:tun_pkg::LO_BITS]);
        part_hh_q[i] <= tun_pkg::HH_BITS'(mag_q[i][tun_pkg::MAG_BITS-1:tun_pkg::LO_BITS]) *
                        tun_pkg::HH_BITS'(mag_q[i][tun_pkg::MAG_BITS-1:tun_pkg::LO_BITS]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (tun_pkg::SQ_BITS'(part_hh_q[i]) << (2 * tun_pkg::LO_BITS)) +
                   (tun_pkg::SQ_BITS'(part_lh_q[i]) << (tun_pkg::LO_BITS + 1)) +
                   tun_pkg::SQ_BITS'(part_ll_q[i]);
      end
    end
  end

  // Squared length.
  logic [tun_pkg::SUM_BITS-1:0] sum_q;
  logic [tun_pkg::SQ_BITS-1:0]  num_q [3];

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_SUM]) begin
      sum_q <= tun_pkg::SUM_BITS'(sq_q[0]) + tun_pkg::SUM_BITS'(sq_q[1]) +
               tun_pkg::SUM_BITS'(sq_q[2]);
      num_q <= sq_q;
    end
  end

  // Restoring division of the squared component, scaled, by the squared
  // length, one quotient bit per stage.
  logic [tun_pkg::REM_BITS-1:0] rem_q     [tun_pkg::QUO_BITS][3];
  logic [tun_pkg::QUO_BITS-1:0] quo_q     [tun_pkg::QUO_BITS][3];
  logic [tun_pkg::SUM_BITS-1:0] div_sum_q [tun_pkg::QUO_BITS];
  logic [NS-2:tun_pkg::ST_DIV]  zero_q;

  for (genvar d = 0; d < tun_pkg::QUO_BITS; d++) begin : g_div
    logic [tun_pkg::REM_BITS-1:0] rem_in [3];
    logic [tun_pkg::QUO_BITS-1:0] quo_in [3];
    logic [tun_pkg::SUM_BITS-1:0] sum_in;
    logic [2:0]                   ge;

    if (d == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = tun_pkg::REM_BITS'(num_q[i]);
          quo_in[i] = '0;
        end
      end
      assign sum_in = sum_q;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {rem_q[d-1][i][tun_pkg::REM_BITS-2:0], 1'b0};
          quo_in[i] = quo_q[d-1][i];
        end
      end
      assign sum_in = div_sum_q[d-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = rem_in[i] >= tun_pkg::REM_BITS'(sum_in);
      end
    end

    always_ff @(posedge clk_i) begin
      if (mv[tun_pkg::ST_DIV + d]) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[d][i] <= ge[i] ? rem_in[i] - tun_pkg::REM_BITS'(sum_in) : rem_in[i];
          quo_q[d][i] <= {quo_in[i][tun_pkg::QUO_BITS-2:0], ge[i]};
        end
        div_sum_q[d] <= sum_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_DIV]) begin
      zero_q[tun_pkg::ST_DIV] <= (sum_q == '0);
    end
  end

  for (genvar k = tun_pkg::ST_DIV + 1; k < NS - 1; k++) begin : g_zero
    always_ff @(posedge clk_i) begin
      if (mv[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // Integer square root of the quotient, one root bit per stage.
  logic [tun_pkg::SR_BITS-1:0]   srem_q [tun_pkg::ROOT_BITS][3];
  logic [tun_pkg::ROOT_BITS-1:0] root_q [tun_pkg::ROOT_BITS][3];

  for (genvar j = 0; j < tun_pkg::ROOT_BITS; j++) begin : g_root
    localparam int unsigned B = tun_pkg::ROOT_BITS - 1 - j;
    logic [tun_pkg::SR_BITS-1:0]   srem_in [3];
    logic [tun_pkg::ROOT_BITS-1:0] root_in [3];
    logic [tun_pkg::SR_BITS-1:0]   trial   [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          srem_in[i] = tun_pkg::SR_BITS'(quo_q[tun_pkg::QUO_BITS-1][i]);
          root_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          srem_in[i] = srem_q[j-1][i];
          root_in[i] = root_q[j-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (tun_pkg::SR_BITS'(root_in[i]) << (B + 1)) +
                   (tun_pkg::SR_BITS'(1) << (2 * B));
      end
    end

    always_ff @(posedge clk_i) begin
      if (mv[tun_pkg::ST_ROOT + j]) begin
        for (int i = 0; i < 3; i++) begin
          if (srem_in[i] >= trial[i]) begin
            srem_q[j][i] <= srem_in[i] - trial[i];
            root_q[j][i] <= root_in[i] | (tun_pkg::ROOT_BITS'(1) << B);
          end else begin
            srem_q[j][i] <= srem_in[i];
            root_q[j][i] <= root_in[i];
          end
        end
      end
    end
  end

  // Round half away from zero, clamp, apply sign; zero for a degenerate triangle.
  logic [tun_pkg::ROOT_BITS:0]   rnd   [3];
  logic [tun_pkg::ROOT_BITS-1:0] qmag  [3];
  logic [tun_pkg::OUT_BITS-1:0]  comp  [3];
  tun_pkg::out_t                 out_d;
  tun_pkg::out_t                 out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = (tun_pkg::ROOT_BITS + 1)'(1) + (tun_pkg::ROOT_BITS + 1)'(
                root_q[tun_pkg::ROOT_BITS-1][i]);
      qmag[i] = rnd[i][tun_pkg::ROOT_BITS:1];
      if (qmag[i] > tun_pkg::ROOT_BITS'(tun_pkg::NORMAL_ONE)) begin
        qmag[i] = tun_pkg::ROOT_BITS'(tun_pkg::NORMAL_ONE);
      end
      if (zero_q[NS-2]) begin
        comp[i] = '0;
      end else if (neg_q[NS-2][i]) begin
        comp[i] = -tun_pkg::OUT_BITS'(qmag[i]);
      end else begin
        comp[i] = tun_pkg::OUT_BITS'(qmag[i]);
      end
    end
    out_d.normal_x   = comp[0];
    out_d.normal_y   = comp[1];
    out_d.normal_z   = comp[2];
    out_d.degenerate = zero_q[NS-2];
  end

  always_ff @(posedge clk_i) begin
    if (mv[tun_pkg::ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_data_o  = out_q;

endmodule

// File: hdl/tun_checker.sv
// ----------------------------------------------------------------------------
// Triangle unit normal checker
// Watches the result port of the triangle unit normal block.
// ----------------------------------------------------------------------------
module tun_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input tun_pkg::out_t out_data_o
);

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Result word changed while stalled.");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0)
    else $error("Degenerate triangle with a nonzero normal.");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.normal_x <= tun_pkg::NORMAL_ONE &&
      out_data_o.normal_x >= -tun_pkg::NORMAL_ONE &&
      out_data_o.normal_y <= tun_pkg::NORMAL_ONE &&
      out_data_o.normal_y >= -tun_pkg::NORMAL_ONE &&
      out_data_o.normal_z <= tun_pkg::NORMAL_ONE &&
      out_data_o.normal_z >= -tun_pkg::NORMAL_ONE)
    else $error("Normal component beyond unit range.");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
